@@ hw/rtl/lhf_pkg.sv @@
package lhf_pkg;

  // Link supervisor states, encoded as they appear on link_state_o
  typedef enum logic [2:0] {
    LinkBoot     = 3'd0,
    LinkPending  = 3'd1,
    LinkOk       = 3'd2,
    LinkHold     = 3'd3,
    LinkFailsafe = 3'd4
  } link_state_e;

  // Input item kinds; codes five to seven are unused
  typedef enum logic [2:0] {
    ModeTick      = 3'd0,
    ModeHeartbeat = 3'd1,
    ModeHostReady = 3'd2,
    ModeChanWrite = 3'd3,
    ModeChanRead  = 3'd4
  } mode_e;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CfgHbTimeout = 8'd0,
    CfgHoldLimit = 8'd1
  } cfg_reg_e;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned TimeW    = 64;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ChIdxW   = 4;
  localparam int unsigned ChValW   = 11;

  localparam int unsigned NumChannelsDef = 16;

  localparam logic [CfgDataW-1:0] HbTimeoutRst = 32'd500000;
  localparam logic [CfgDataW-1:0] HoldLimitRst = 32'd1000000;

  localparam logic [ChValW-1:0] ChCenter = 11'd992;
  localparam logic [ChValW-1:0] ChLow    = 11'd172;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

@@ hw/rtl/link_heartbeat_failsafe_fsm.sv @@
// Link heartbeat supervisor with failsafe hold. Each transaction on the input
// channel is one timestamped event (tick, heartbeat, host ready, channel write
// or channel read) and yields exactly one result transaction carrying the link
// state after the event, the emit flag and, for reads, the channel value. An
// event enters an input register; the state update and channel store access
// then run as the event moves on and land in a result register, which holds
// it until it is taken; one event is taken every cycle while the output is not
// stalled; the state loop (two 64-bit wrapping subtract-and-compare paths
// feeding the next-state logic) is combinational between the registers.
// Timeout and hold limit are written over the configuration channel, which is
// always ready, and should only change while no event is in flight.
module link_heartbeat_failsafe_fsm
  import lhf_pkg::*;
#(
  parameter int unsigned NumChannels = NumChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ModeW-1:0]    mode_i,
  input  logic [TimeW-1:0]    now_us_i,
  input  logic [ChIdxW-1:0]   channel_index_i,
  input  logic [ChValW-1:0]   channel_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          link_state_o,
  output logic                emit_enable_o,
  output logic [ChValW-1:0]   channel_read_value_o
);

  cfg_wr_t cfg_wr;

  logic              in_vld_q;
  logic [ModeW-1:0]  mode_q;
  logic [TimeW-1:0]  now_q;
  logic [ChIdxW-1:0] ch_idx_q;
  logic [ChValW-1:0] ch_val_q;

  logic              out_vld_q;
  link_state_e       res_state_q;
  logic              res_emit_q;
  logic [ChValW-1:0] res_rd_q;

  logic              advance;
  logic              accept;
  link_state_e       core_state;
  logic              core_emit;
  logic [ChValW-1:0] store_rd;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Move the held event into the result register when that slot is free
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_i;
      now_q    <= now_us_i;
      ch_idx_q <= channel_index_i;
      ch_val_q <= channel_value_i;
    end
  end

  lhf_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_wr),
    .step_i  (advance),
    .mode_i  (mode_q),
    .now_i   (now_q),
    .state_o (core_state),
    .emit_o  (core_emit)
  );

  lhf_chan_store #(
    .NumChannels (NumChannels)
  ) u_chan_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .mode_i    (mode_q),
    .ch_idx_i  (ch_idx_q),
    .ch_val_i  (ch_val_q),
    .rd_data_o (store_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_state_q <= core_state;
      res_emit_q  <= core_emit;
      res_rd_q    <= store_rd;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign link_state_o         = res_state_q;
  assign emit_enable_o        = res_emit_q;
  assign channel_read_value_o = res_rd_q;

  a_emit_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_emit_q == ((res_state_q == LinkOk) ||
                                  (res_state_q == LinkHold))))
    else $error("emit flag disagrees with reported state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |-> !advance)
    else $error("pending result overwritten while stalled");

  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (mode_q != ModeChanRead)) |=> (res_rd_q == '0))
    else $error("read data nonzero for a non-read transaction");

endmodule

@@ hw/rtl/lhf_chan_store.sv @@
module lhf_chan_store
  import lhf_pkg::*;
#(
  parameter int unsigned NumChannels = NumChannelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [ChIdxW-1:0] ch_idx_i,
  input  logic [ChValW-1:0] ch_val_i,
  output logic [ChValW-1:0] rd_data_o
);

  // The index port reaches at most 2**ChIdxW entries
  localparam int unsigned Depth = (NumChannels < (1 << ChIdxW)) ? NumChannels
                                                                 : (1 << ChIdxW);
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [ChValW-1:0] store_q [Depth];
  logic              in_range;
  logic [AddrW-1:0]  addr;
  logic              wr_en;

  assign in_range = (32'(ch_idx_i) < 32'(NumChannels));
  assign addr     = ch_idx_i[AddrW-1:0];
  assign wr_en    = step_i && (mode_i == ModeChanWrite) && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        store_q[i] <= ((i == 2) || (i == 4)) ? ChLow : ChCenter;
      end
    end else if (wr_en) begin
      store_q[addr] <= ch_val_i;
    end
  end

  always_comb begin
    rd_data_o = '0;
    if ((mode_i == ModeChanRead) && in_range) begin
      rd_data_o = store_q[addr];
    end
  end

endmodule

@@ hw/rtl/lhf_core.sv @@
module lhf_core
  import lhf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             step_i,
  input  logic [ModeW-1:0] mode_i,
  input  logic [TimeW-1:0] now_i,
  output link_state_e      state_o,
  output logic             emit_o
);

  link_state_e         state_q, state_d;
  logic [TimeW-1:0]    last_hb_q;
  logic [TimeW-1:0]    entry_time_q;
  logic                host_rdy_q;
  logic [CfgDataW-1:0] hb_timeout_q;
  logic [CfgDataW-1:0] hold_limit_q;

  logic [TimeW-1:0] hb_age;
  logic [TimeW-1:0] held;
  logic             hb_expired;
  logic             hold_expired;

  assign hb_age       = now_i - last_hb_q;
  assign held         = now_i - entry_time_q;
  // no heartbeat recorded yet counts as infinite age
  assign hb_expired   = (last_hb_q == '0) || (hb_age > TimeW'(hb_timeout_q));
  assign hold_expired = held > TimeW'(hold_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_timeout_q <= HbTimeoutRst;
      hold_limit_q <= HoldLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CfgHbTimeout: hb_timeout_q <= cfg_i.data;
        CfgHoldLimit: hold_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (mode_i)
      ModeTick: begin
        case (state_q)
          LinkBoot: if (host_rdy_q) state_d = LinkPending;
          LinkOk:   if (hb_expired) state_d = LinkHold;
          LinkHold: if (hold_expired) state_d = LinkFailsafe;
          default: ;
        endcase
      end
      ModeHeartbeat: begin
        if ((state_q == LinkPending) || (state_q == LinkHold) ||
            (state_q == LinkFailsafe)) begin
          state_d = LinkOk;
        end
      end
      ModeHostReady: begin
        if (state_q == LinkBoot) state_d = LinkPending;
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    state_o = state_d;
    emit_o  = (state_d == LinkOk) || (state_d == LinkHold);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= LinkBoot;
      last_hb_q    <= '0;
      entry_time_q <= '0;
      host_rdy_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      if (state_d != state_q) entry_time_q <= now_i;
      if (mode_i == ModeHeartbeat) last_hb_q <= now_i;
      if (mode_i == ModeHostReady) host_rdy_q <= 1'b1;
    end
  end

  a_boot_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_q == LinkBoot) && (state_d != LinkBoot)) |->
      (state_d == LinkPending))
    else $error("boot left for a state other than pending");

  a_hold_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_d == LinkHold) && (state_q != LinkHold)) |->
      ((state_q == LinkOk) && (mode_i == ModeTick)))
    else $error("hold entered other than by a tick in ok");

  a_entry_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (state_d != state_q)) |=> (entry_time_q == $past(now_i)))
    else $error("state entry time not taken on transition");

endmodule
